// ===== hw/rtl/bmd_pkg.sv =====
// bmd_pkg: shared types for the block median decimator
// sample type and the link record passed between neighboring sort cells
// no dependencies
`default_nettype none

package bmd_pkg;

  localparam int SAMPLE_W = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // what a cell hands to its right-hand neighbor
  typedef struct packed {
    sample_t val;
    logic    valid;
    logic    lt;     // new sample sorts in front of this cell's value
  } bmd_link_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bmd_cell.sv =====
// bmd_cell: one slot of a sorted insertion chain
// holds one sample and shifts right when a smaller sample is inserted ahead of it
// depends on bmd_pkg
`default_nettype none

module bmd_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               ins,
  input  wire logic               clr,
  input  wire bmd_pkg::sample_t   din,
  input  wire bmd_pkg::bmd_link_t left,
  output bmd_pkg::bmd_link_t      right
);
  import bmd_pkg::*;

  sample_t val_r, val_nxt;
  logic    valid_r, valid_nxt;
  logic    my_lt;

  // an empty slot counts as larger than any sample; ties keep arrival order
  assign my_lt = !valid_r || (din < val_r);

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (clr) begin
      valid_nxt = 1'b0;
    end else if (ins && my_lt) begin
      if (left.lt) begin
        val_nxt   = left.val;
        valid_nxt = left.valid;
      end else begin
        val_nxt   = din;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign right.val   = val_r;
  assign right.valid = valid_r;
  assign right.lt    = my_lt;

endmodule

`default_nettype wire

// ===== hw/rtl/bmd_chain.sv =====
// bmd_chain: row of sort cells for one channel, kept in ascending order
// the median is the value of a fixed cell of the row
// depends on bmd_pkg, bmd_cell
`default_nettype none

module bmd_chain #(
  parameter int DEPTH = 7,
  parameter int MID   = 3
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             ins,
  input  wire logic             clr,
  input  wire bmd_pkg::sample_t din,
  output bmd_pkg::sample_t      med
);
  import bmd_pkg::*;

  bmd_link_t link [DEPTH+1];

  // head of the chain: nothing in front of cell 0
  assign link[0].val   = din;
  assign link[0].valid = 1'b0;
  assign link[0].lt    = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bmd_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ins   (ins),
      .clr   (clr),
      .din   (din),
      .left  (link[i]),
      .right (link[i+1])
    );
  end

  assign med = link[MID+1].val;

endmodule

`default_nettype wire

// ===== hw/rtl/block_median_decimator_core.sv =====
// block_median_decimator_core: two-channel block median with decimation
// takes one item per cycle; busy is never raised. an item that finds WINDOW-1
// samples held gives its result in the next cycle (out_valid for one cycle).
// each sample is placed in sorted order as it arrives by a row of compare cells,
// so the median is ready without a separate sort pass.
// rst_n (synchronous) empties both rows; sample contents are not cleared.
`default_nettype none

module block_median_decimator_core #(
  parameter int WINDOW = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire bmd_pkg::sample_t in_vel_x,
  input  wire bmd_pkg::sample_t in_vel_y,
  output logic                  out_valid,
  output bmd_pkg::sample_t      out_med_x,
  output bmd_pkg::sample_t      out_med_y
);
  import bmd_pkg::*;

  localparam int DEPTH = WINDOW - 1;
  localparam int MID   = (WINDOW - 1) / 2;
  localparam int CNT_W = $clog2(WINDOW);

  logic [CNT_W-1:0] fill_count_r, fill_count_nxt;
  logic             out_valid_r, out_valid_nxt;
  sample_t          med_x_r, med_y_r;
  sample_t          chain_med_x, chain_med_y;
  logic             accept, full, ins, clr;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (fill_count_r == CNT_W'(DEPTH));
  assign ins    = accept && !full;
  // the item that finds the rows full is dropped and flushes them
  assign clr    = accept && full;

  bmd_chain #(.DEPTH(DEPTH), .MID(MID)) u_chain_x (
    .clk   (clk),
    .rst_n (rst_n),
    .ins   (ins),
    .clr   (clr),
    .din   (in_vel_x),
    .med   (chain_med_x)
  );

  bmd_chain #(.DEPTH(DEPTH), .MID(MID)) u_chain_y (
    .clk   (clk),
    .rst_n (rst_n),
    .ins   (ins),
    .clr   (clr),
    .din   (in_vel_y),
    .med   (chain_med_y)
  );

  always_comb begin
    fill_count_nxt = fill_count_r;
    if (clr) begin
      fill_count_nxt = '0;
    end else if (ins) begin
      fill_count_nxt = fill_count_r + CNT_W'(1);
    end
    out_valid_nxt = clr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      fill_count_r <= fill_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      med_x_r <= chain_med_x;
      med_y_r <= chain_med_y;
    end
  end

  assign out_valid = out_valid_r;
  assign out_med_x = med_x_r;
  assign out_med_y = med_y_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= CNT_W'(DEPTH))
    else $error("fill count beyond row depth");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> out_valid)
    else $error("flushing item gave no result");

  a_result_only_on_flush: assert property (@(posedge clk) disable iff (!rst_n)
    !clr |=> !out_valid)
    else $error("result without a flushing item");

  a_empty_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> fill_count_r == '0)
    else $error("rows not emptied with the result");

endmodule

`default_nettype wire

// ===== sim/block_median_decimator_core_tb.sv =====
// block_median_decimator_core_tb: self-checking bench for the block median decimator
// drives x/y velocity items, predicts each block median with a sorting model and
// compares out_med_x/out_med_y; depends on bmd_pkg and block_median_decimator_core
`timescale 1ns / 1ps

module block_median_decimator_core_tb;
  import bmd_pkg::*;

  localparam int WINDOW     = 8;
  localparam int DEPTH      = WINDOW - 1;
  localparam int MID_RANK   = (WINDOW - 1) / 2;
  localparam int N_DIRECTED = 24;
  localparam int N_RANDOM   = 1950;
  localparam int N_CALM     = 200;   // trailing items sent back to back
  localparam int QUIET_MAX  = 1000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYC  = 8;

  typedef struct packed {
    sample_t mx;
    sample_t my;
  } median_t;

  typedef struct packed {
    sample_t x;
    sample_t y;
    logic    known;
    sample_t ex;
    sample_t ey;
  } stim_row_t;

  logic    clk;
  logic    rst_n;
  logic    start;
  logic    busy;
  sample_t in_vel_x;
  sample_t in_vel_y;
  logic    out_valid;
  sample_t out_med_x;
  sample_t out_med_y;

  // typed expectation riding along with the item being driven
  logic    drv_known;
  sample_t drv_ex;
  sample_t drv_ey;

  sample_t held_x[DEPTH];
  sample_t held_y[DEPTH];
  int      held_cnt;
  median_t pending_medians[$];

  int items_taken;
  int medians_seen;
  int errors;
  int quiet_cycles;

  block_median_decimator_core #(.WINDOW(WINDOW)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_vel_x  (in_vel_x),
    .in_vel_y  (in_vel_y),
    .out_valid (out_valid),
    .out_med_x (out_med_x),
    .out_med_y (out_med_y)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // value of rank MID_RANK among the held samples, smallest first
  function automatic sample_t rank_middle(input sample_t vals[DEPTH]);
    sample_t sorted[DEPTH];
    sample_t v;
    int j;
    for (int i = 0; i < DEPTH; i++) begin
      v = vals[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    return sorted[MID_RANK];
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return sample_t'($signed($urandom_range(0, 6)) - 3);  // tight cluster, many ties
      3: return sample_t'($urandom_range(0, 3) * 16'h4000);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // result check first, then prediction, so a result and a new item on the same edge cannot race
  always @(posedge clk) begin
    median_t want;
    logic took;
    took = 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        took = 1'b1;
        if (pending_medians.size() == 0) begin
          errors++;
          $display("%0t: unexpected result med_x=%0d med_y=%0d", $time, out_med_x, out_med_y);
        end else begin
          want = pending_medians.pop_front();
          medians_seen++;
          if (out_med_x !== want.mx) begin
            errors++;
            $display("%0t: med_x expected %0d got %0d", $time, want.mx, out_med_x);
          end
          if (out_med_y !== want.my) begin
            errors++;
            $display("%0t: med_y expected %0d got %0d", $time, want.my, out_med_y);
          end
        end
      end
      if (start && !busy) begin
        took = 1'b1;
        items_taken++;
        if (held_cnt == DEPTH) begin
          // full store: this item is dropped and the block median goes out
          if (drv_known) begin
            want.mx = drv_ex;
            want.my = drv_ey;
          end else begin
            want.mx = rank_middle(held_x);
            want.my = rank_middle(held_y);
          end
          pending_medians = {pending_medians, want};
          held_cnt = 0;
        end else begin
          held_x[held_cnt] = in_vel_x;
          held_y[held_cnt] = in_vel_y;
          held_cnt++;
        end
      end
    end
    quiet_cycles = took ? 0 : quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_MAX) @(posedge clk);
    $display("watchdog: no handshake for %0d cycles", QUIET_MAX);
    $display("Some tests failed");
    $finish;
  end

  // call at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(input sample_t x, input sample_t y, input logic known,
                           input sample_t ex, input sample_t ey);
    int target;
    start     <= 1'b1;
    in_vel_x  <= x;
    in_vel_y  <= y;
    drv_known <= known;
    drv_ex    <= ex;
    drv_ey    <= ey;
    target = items_taken + 1;
    do @(negedge clk); while (items_taken != target);
  endtask

  task automatic idle_for(input int cycles);
    start     <= 1'b0;
    drv_known <= 1'b0;
    in_vel_x  <= sample_t'($urandom());
    in_vel_y  <= sample_t'($urandom());
    repeat (cycles) @(negedge clk);
  endtask

  initial begin
    stim_row_t directed_rows[N_DIRECTED];
    logic paused;
    directed_rows = '{
      // all-max x, all-min y
      '{16'sh7fff, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
      '{16'sh7fff, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
      '{16'sh7fff, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
      '{16'sh7fff, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
      '{16'sh7fff, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
      '{16'sh7fff, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
      '{16'sh7fff, 16'sh8000, 1'b0, 16'sh0, 16'sh0},
      '{16'sh0000, 16'sh0000, 1'b1, 16'sh7fff, 16'sh8000},
      // all-min x, all-max y; dropped item carries the opposite extremes
      '{16'sh8000, 16'sh7fff, 1'b0, 16'sh0, 16'sh0},
      '{16'sh8000, 16'sh7fff, 1'b0, 16'sh0, 16'sh0},
      '{16'sh8000, 16'sh7fff, 1'b0, 16'sh0, 16'sh0},
      '{16'sh8000, 16'sh7fff, 1'b0, 16'sh0, 16'sh0},
      '{16'sh8000, 16'sh7fff, 1'b0, 16'sh0, 16'sh0},
      '{16'sh8000, 16'sh7fff, 1'b0, 16'sh0, 16'sh0},
      '{16'sh8000, 16'sh7fff, 1'b0, 16'sh0, 16'sh0},
      '{16'sh7fff, 16'sh8000, 1'b1, 16'sh8000, 16'sh7fff},
      // mixed signs with ties around the middle rank
      '{16'sh0005, 16'sh0003, 1'b0, 16'sh0, 16'sh0},
      '{16'shfffe, 16'sh0003, 1'b0, 16'sh0, 16'sh0},
      '{16'sh0005, 16'shfff9, 1'b0, 16'sh0, 16'sh0},
      '{16'sh7fff, 16'shfff9, 1'b0, 16'sh0, 16'sh0},
      '{16'sh8000, 16'sh0064, 1'b0, 16'sh0, 16'sh0},
      '{16'sh0005, 16'shff9c, 1'b0, 16'sh0, 16'sh0},
      '{16'sh0000, 16'sh0003, 1'b0, 16'sh0, 16'sh0},
      '{16'sh04d2, 16'shfb2e, 1'b0, 16'sh0, 16'sh0}
    };
    paused       = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_vel_x     = '0;
    in_vel_y     = '0;
    drv_known    = 1'b0;
    drv_ex       = '0;
    drv_ey       = '0;
    held_cnt     = 0;
    items_taken  = 0;
    medians_seen = 0;
    errors       = 0;
    quiet_cycles = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].x, directed_rows[i].y, directed_rows[i].known,
                directed_rows[i].ex, directed_rows[i].ey);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i < N_RANDOM - N_CALM && $urandom_range(0, 3) == 0)
        idle_for($urandom_range(1, 19));
      send_item(rand_sample(), rand_sample(), 1'b0, '0, '0);
      // hold the sender off once until the pending median has come out
      if (!paused && i >= N_RANDOM / 2 && pending_medians.size() != 0) begin
        paused = 1'b1;
        start <= 1'b0;
        while (pending_medians.size() != 0) @(negedge clk);
      end
    end
    start     <= 1'b0;
    drv_known <= 1'b0;

    while (pending_medians.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);

    $display("sent %0d items (%0d directed, rest random with idle bursts)", items_taken,
             N_DIRECTED);
    $display("checked %0d block medians of %0d samples each", medians_seen, DEPTH);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
